@@ design/skt_pkg.sv @@
// shared types and constants of the sorted key table
package skt_pkg;

   // transfer widths of the fixed item fields
   localparam int OP_W       = 3;
   localparam int KEY_W      = 32;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int POS_W      = 4;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT     = 3'd0,
      OP_DELETE     = 3'd1,
      OP_LOOKUP     = 3'd2,
      OP_REPLACE    = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_ITER_RESET = 3'd5,
      OP_ITER_NEXT  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_END       = 3'd4
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic compare;
      logic update;
   } cmd_type;

endpackage

@@ design/sorted_key_table.sv @@
// top level of the sorted key table: controller, cell datapath and checks
// a request is captured, then compared over all cells in parallel, then the cells
// shift and the result register is written; the update waits while a response is pending
// a new request may be taken in the update state, as the previous result is written
// reset: synchronous, clears entry count, cursor and handshake state; cells are not cleared
// and no clearing pass runs, so the table takes requests in the cycle after reset
module sorted_key_table #(
   parameter int DEPTH     = 16,
   parameter int KEY_BITS  = 32,
   parameter int DATA_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [skt_pkg::REQ_DATA_W-1:0]   req_tdata,  // key[31:0], payload[63:32]
   input  logic [skt_pkg::OP_W-1:0]         req_tuser,  // operation[2:0]
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [skt_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // found_key[31:0], found_payload[63:32],
                                                        // position[67:64], entry_count[72:68],
                                                        // is_full[73], is_empty[74], zero[79:75]
   output logic [skt_pkg::STATUS_W-1:0]     rsp_tuser   // status[2:0]
);
   import skt_pkg::*;

   cmd_type              cmd;
   logic [KEY_W-1:0]     rsp_key;
   logic [DATA_W-1:0]    rsp_payload;
   logic [POS_W-1:0]     rsp_position;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 rsp_full, rsp_empty;

   // sequencer: accept, compare, update; a new request may enter on the update cycle
   skt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // sorted cells with parallel compare and shift on update
   skt_datapath #(
      .DEPTH     (DEPTH),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_op       (req_tuser),
      .req_key      (req_tdata[KEY_W-1:0]),
      .req_payload  (req_tdata[KEY_W+DATA_W-1:KEY_W]),
      .rsp_status   (rsp_tuser),
      .rsp_key      (rsp_key),
      .rsp_payload  (rsp_payload),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_full     (rsp_full),
      .rsp_empty    (rsp_empty)
   );

   // pack the response fields from the lowest bit up
   assign rsp_tdata = {5'b0, rsp_empty, rsp_full, rsp_count, rsp_position,
                       rsp_payload, rsp_key};

   // every accepted request is captured by the datapath
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> cmd.load)
      else $error("request transfer without datapath load");

   // a captured request is compared in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.compare)
      else $error("load not followed by compare");

   // the result register is only written when the slot is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_tvalid || rsp_tready))
      else $error("update overwrote a pending response");

   // a response appears only after an update
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.update))
      else $error("response valid without update");

   // full and empty never hold together
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_full && rsp_empty))
      else $error("response reports full and empty");

endmodule

@@ design/skt_ctrl.sv @@
// controller state machine of the sorted key table
module skt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output skt_pkg::cmd_type cmd
);
   import skt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               req_tready   = 1'b1;
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = S_COMPARE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/skt_datapath.sv @@
// cell array, compare flags and result register of the sorted key table
module skt_datapath #(
   parameter int DEPTH     = 16,
   parameter int KEY_BITS  = 32,
   parameter int DATA_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  skt_pkg::cmd_type               cmd,
   input  logic [skt_pkg::OP_W-1:0]       req_op,
   input  logic [skt_pkg::KEY_W-1:0]      req_key,
   input  logic [skt_pkg::DATA_W-1:0]     req_payload,
   output logic [skt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [skt_pkg::KEY_W-1:0]      rsp_key,
   output logic [skt_pkg::DATA_W-1:0]     rsp_payload,
   output logic [skt_pkg::POS_W-1:0]      rsp_position,
   output logic [skt_pkg::COUNT_W-1:0]    rsp_count,
   output logic                           rsp_full,
   output logic                           rsp_empty
);
   import skt_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   // captured item
   op_type                 op_ff;
   logic [KEY_BITS-1:0]    new_key_ff;
   logic [DATA_BITS-1:0]   new_data_ff;

   // cells
   logic [KEY_BITS-1:0]    key_ff  [DEPTH];
   logic [DATA_BITS-1:0]   data_ff [DEPTH];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       cursor_ff, cursor_in;

   // compare stage
   logic [DEPTH-1:0]       lt_in, eq_in;
   logic [CNT_W-1:0]       at_in, at_ff;
   logic                   found_ff;
   logic [KEY_BITS-1:0]    sel_key_in, sel_key_ff;
   logic [DATA_BITS-1:0]   sel_data_in, sel_data_ff;

   // result
   status_type             status_in, status_ff;
   logic [KEY_BITS-1:0]    fkey_in;
   logic [DATA_BITS-1:0]   fdata_in;
   logic [CNT_W-1:0]       pos_in;
   logic [KEY_W-1:0]       fkey_ff;
   logic [DATA_W-1:0]      fdata_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [COUNT_W-1:0]     cnt_out_ff;
   logic                   full_ff, empty_ff;
   logic                   table_full, insert_ok;

   assign table_full = (count_ff == CNT_W'(DEPTH));
   assign insert_ok  = !table_full && !found_ff;

   // parallel compare of every held cell against the captured key
   always_comb begin
      at_in       = '0;
      sel_key_in  = '0;
      sel_data_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         lt_in[i] = (CNT_W'(i) < count_ff) && (key_ff[i] < new_key_ff);
         eq_in[i] = (CNT_W'(i) < count_ff) && (key_ff[i] == new_key_ff);
      end
      for (int i = 0; i < DEPTH; i++) begin
         // sorted cells give a thermometer, its top edge is the lower bound
         if (lt_in[i] && (i == DEPTH - 1 || !lt_in[(i == DEPTH - 1) ? i : i + 1])) begin
            at_in = at_in | CNT_W'(i + 1);
         end
         if (eq_in[i]) begin
            sel_key_in  = sel_key_in | key_ff[i];
            sel_data_in = sel_data_in | data_ff[i];
         end
      end
      if (op_ff == OP_ITER_NEXT) begin
         sel_key_in  = '0;
         sel_data_in = '0;
         if (cursor_ff < count_ff) begin
            sel_key_in  = key_ff[cursor_ff[IDX_W-1:0]];
            sel_data_in = data_ff[cursor_ff[IDX_W-1:0]];
         end
      end
   end

   // result and next count and cursor
   always_comb begin
      status_in = ST_OK;
      fkey_in   = '0;
      fdata_in  = '0;
      pos_in    = '0;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      case (op_ff)
         OP_INSERT: begin
            if (table_full) begin
               status_in = ST_FULL;
            end else if (found_ff) begin
               status_in = ST_DUPLICATE;
            end else begin
               pos_in   = at_ff;
               count_in = count_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            if (!found_ff) begin
               status_in = ST_NOT_FOUND;
            end else begin
               pos_in   = at_ff;
               count_in = count_ff - 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (!found_ff) begin
               status_in = ST_NOT_FOUND;
            end else begin
               fkey_in  = sel_key_ff;
               fdata_in = sel_data_ff;
               pos_in   = at_ff;
            end
         end
         OP_REPLACE: begin
            if (!found_ff) begin
               status_in = ST_NOT_FOUND;
            end else begin
               pos_in = at_ff;
            end
         end
         OP_CLEAR: begin
            count_in  = '0;
            cursor_in = '0;
         end
         OP_ITER_RESET: begin
            cursor_in = '0;
         end
         OP_ITER_NEXT: begin
            if (cursor_ff >= count_ff) begin
               status_in = ST_END;
               cursor_in = count_ff;
            end else begin
               fkey_in   = sel_key_ff;
               fdata_in  = sel_data_ff;
               pos_in    = cursor_ff;
               cursor_in = cursor_ff + 1'b1;
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   // one cell: keep, take the new entry, or take a neighbor
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam int PREV = (g == 0) ? 0 : g - 1;
      localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;
      always_ff @(posedge clock) begin
         if (cmd.update) begin
            case (op_ff)
               OP_INSERT: begin
                  if (insert_ok) begin
                     if (CNT_W'(g) == at_ff) begin
                        key_ff[g]  <= new_key_ff;
                        data_ff[g] <= new_data_ff;
                     end else if (CNT_W'(g) > at_ff && CNT_W'(g) <= count_ff) begin
                        key_ff[g]  <= key_ff[PREV];
                        data_ff[g] <= data_ff[PREV];
                     end
                  end
               end
               OP_DELETE: begin
                  if (found_ff && CNT_W'(g) >= at_ff && (CNT_W'(g) + 1'b1) < count_ff) begin
                     key_ff[g]  <= key_ff[NEXT];
                     data_ff[g] <= data_ff[NEXT];
                  end
               end
               OP_REPLACE: begin
                  if (found_ff && CNT_W'(g) == at_ff) begin
                     data_ff[g] <= new_data_ff;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
      end else if (cmd.update) begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= op_type'(req_op);
         new_key_ff  <= KEY_BITS'(req_key);
         new_data_ff <= DATA_BITS'(req_payload);
      end
      if (cmd.compare) begin
         at_ff       <= at_in;
         found_ff    <= |eq_in;
         sel_key_ff  <= sel_key_in;
         sel_data_ff <= sel_data_in;
      end
      if (cmd.update) begin
         status_ff  <= status_in;
         fkey_ff    <= KEY_W'(fkey_in);
         fdata_ff   <= DATA_W'(fdata_in);
         pos_ff     <= POS_W'(pos_in);
         cnt_out_ff <= COUNT_W'(count_in);
         full_ff    <= (count_in == CNT_W'(DEPTH));
         empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_status   = status_ff;
   assign rsp_key      = fkey_ff;
   assign rsp_payload  = fdata_ff;
   assign rsp_position = pos_ff;
   assign rsp_count    = cnt_out_ff;
   assign rsp_full     = full_ff;
   assign rsp_empty    = empty_ff;

endmodule

@@ dv/sorted_key_table_test.sv @@
// testbench of the sorted key table: directed and random operation streams against a scoreboard
`timescale 1ns / 1ps

module sorted_key_table_test;
   import skt_pkg::*;

   typedef struct packed {
      status_type             status;
      logic [KEY_W-1:0]       found_key;
      logic [DATA_W-1:0]      found_payload;
      logic [POS_W-1:0]       position;
      logic [COUNT_W-1:0]     entry_count;
      logic                   is_full;
      logic                   is_empty;
   } table_result_type;

   class key_table_scoreboard;
      localparam int CAPACITY = 16;

      // the table as it should stand after every accepted request
      logic [KEY_W-1:0]  held_keys[CAPACITY];
      logic [DATA_W-1:0] held_payloads[CAPACITY];
      int                entry_total;
      int                walk_index;
      table_result_type  expected_results[$];
      int                errors;
      int                responses;
      int                status_seen[8];
      int                full_seen;
      int                empty_seen;

      function new();
         entry_total = 0;
         walk_index  = 0;
         errors      = 0;
         responses   = 0;
         full_seen   = 0;
         empty_seen  = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [DATA_W-1:0] payload);
         table_result_type r;
         int               slot;
         bit               hit;
         r = '0;
         r.status = ST_OK;
         slot = 0;
         while (slot < entry_total && held_keys[slot] < key) slot++;
         hit = (slot < entry_total) && (held_keys[slot] == key);
         case (op)
            OP_INSERT: begin
               // a full table refuses before the duplicate test
               if (entry_total >= CAPACITY) r.status = ST_FULL;
               else if (hit) r.status = ST_DUPLICATE;
               else begin
                  for (int i = entry_total; i > slot; i--) begin
                     held_keys[i]     = held_keys[i-1];
                     held_payloads[i] = held_payloads[i-1];
                  end
                  held_keys[slot]     = key;
                  held_payloads[slot] = payload;
                  entry_total++;
                  r.position = POS_W'(slot);
               end
            end
            OP_DELETE: begin
               if (!hit) r.status = ST_NOT_FOUND;
               else begin
                  for (int i = slot; i + 1 < entry_total; i++) begin
                     held_keys[i]     = held_keys[i+1];
                     held_payloads[i] = held_payloads[i+1];
                  end
                  entry_total--;
                  r.position = POS_W'(slot);
               end
            end
            OP_LOOKUP: begin
               if (!hit) r.status = ST_NOT_FOUND;
               else begin
                  r.found_key     = held_keys[slot];
                  r.found_payload = held_payloads[slot];
                  r.position      = POS_W'(slot);
               end
            end
            OP_REPLACE: begin
               if (!hit) r.status = ST_NOT_FOUND;
               else begin
                  held_payloads[slot] = payload;
                  r.position = POS_W'(slot);
               end
            end
            OP_CLEAR: begin
               entry_total = 0;
               walk_index  = 0;
            end
            OP_ITER_RESET: walk_index = 0;
            OP_ITER_NEXT: begin
               // the cursor is not moved by insert or delete, so it may lie past the end
               if (walk_index >= entry_total) begin
                  r.status   = ST_END;
                  walk_index = entry_total;
               end else begin
                  r.found_key     = held_keys[walk_index];
                  r.found_payload = held_payloads[walk_index];
                  r.position      = POS_W'(walk_index);
                  walk_index++;
               end
            end
            default: ;
         endcase
         r.entry_count = COUNT_W'(entry_total);
         r.is_full     = (entry_total == CAPACITY);
         r.is_empty    = (entry_total == 0);
         expected_results.push_back(r);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data,
                                   logic [STATUS_W-1:0] user);
         table_result_type want;
         if (expected_results.size() == 0) begin
            $error("response transfer with no request outstanding");
            errors++;
            return;
         end
         want = expected_results.pop_front();
         responses++;
         status_seen[want.status]++;
         if (want.is_full) full_seen++;
         if (want.is_empty) empty_seen++;
         if (user != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, user);
            errors++;
         end
         if (data[31:0] != want.found_key) begin
            $error("found_key: expected %h, actual %h", want.found_key, data[31:0]);
            errors++;
         end
         if (data[63:32] != want.found_payload) begin
            $error("found_payload: expected %h, actual %h", want.found_payload,
                   data[63:32]);
            errors++;
         end
         if (data[67:64] != want.position) begin
            $error("position: expected %0d, actual %0d", want.position, data[67:64]);
            errors++;
         end
         if (data[72:68] != want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   data[72:68]);
            errors++;
         end
         if (data[73] != want.is_full) begin
            $error("is_full: expected %0d, actual %0d", want.is_full, data[73]);
            errors++;
         end
         if (data[74] != want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, data[74]);
            errors++;
         end
      endfunction
   endclass

   localparam logic [OP_W-1:0] OP_UNKNOWN   = 3'd7;
   localparam int              RANDOM_ITEMS = 1100;
   localparam int              CYCLE_LIMIT  = 600000;
   localparam int              HOLD_CYCLES  = 400;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata = '0;   // key[31:0], payload[63:32]
   logic [OP_W-1:0]          req_tuser = '0;   // operation[2:0]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]    rsp_tdata;        // found_key, found_payload, position,
                                               // entry_count, is_full, is_empty
   logic [STATUS_W-1:0]      rsp_tuser;        // status[2:0]

   key_table_scoreboard sb = new();

   // shared between the request and response processes
   bit                quiet = 1'b0;       // no idling on either side
   bit                hold_request = 1'b0;
   int                holdoffs = 0;
   logic [KEY_W-1:0]  key_pool[24];

   sorted_key_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // small pool so that hits, duplicates and a full table come up often
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 23)];
      return $urandom;
   endfunction

   // key that the table holds now, when there is one
   function automatic logic [KEY_W-1:0] pick_held_key();
      if (sb.entry_total > 0 && $urandom_range(0, 1) == 1)
         return sb.held_keys[$urandom_range(0, sb.entry_total - 1)];
      return pick_key();
   endfunction

   // one request transfer; valid stays high across back-to-back transfers
   task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [DATA_W-1:0] payload);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {payload, key};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, key, payload);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side: check each transfer, then decide readiness for the next edge
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         if (hold_request) begin
            // long hold-off so the block backs up and stalls its input
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
            holdoffs++;
         end
         if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("sorted_key_table_test: errors");
      $finish;
   end

   initial begin
      int               sent;
      int               roll;
      int               insert_top;
      int               walk_len;
      bit               hold_done;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;

      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7fff_ffff;
      for (int i = 4; i < 24; i++) key_pool[i] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table cases, extremes of key and payload, iterator ends
      send_request(OP_LOOKUP, 32'd5, '0);
      send_request(OP_DELETE, 32'd5, '0);
      send_request(OP_REPLACE, 32'd5, '1);
      send_request(OP_ITER_NEXT, '0, '0);
      send_request(OP_INSERT, 32'h8000_0000, '1);
      send_request(OP_INSERT, '0, '0);
      send_request(OP_INSERT, '1, 32'haaaa_aaaa);
      send_request(OP_INSERT, '0, 32'h1234_5678);     // duplicate key
      send_request(OP_INSERT, 32'd5, 32'h5555_5555);
      send_request(OP_LOOKUP, '0, '0);
      send_request(OP_LOOKUP, '1, '0);
      send_request(OP_REPLACE, 32'd5, 32'hffff_0000);
      send_request(OP_LOOKUP, 32'd5, '0);
      send_request(OP_LOOKUP, 32'd6, '0);
      send_request(OP_ITER_RESET, '0, '0);
      repeat (5) send_request(OP_ITER_NEXT, '0, '0);  // four entries, then end of list
      send_request(OP_ITER_NEXT, '0, '0);             // cursor stays at the end
      send_request(OP_DELETE, 32'h8000_0000, '0);
      send_request(OP_DELETE, 32'h8000_0000, '0);
      send_request(OP_UNKNOWN, '1, '1);
      send_request(OP_CLEAR, '0, '0);
      send_request(OP_ITER_NEXT, '0, '0);

      // random: blocks alternate between filling and draining the table
      sent = 0;
      hold_done = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         quiet      = ((sent / 100) % 3 == 2);
         insert_top = ((sent / 100) % 2 == 0) ? 45 : 20;
         if (!hold_done && sent >= 300) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 4 && sb.entry_total > 0) begin
            // full walk of the table, one past the end
            walk_len = sb.entry_total + 1;
            send_request(OP_ITER_RESET, $urandom, $urandom);
            repeat (walk_len) send_request(OP_ITER_NEXT, $urandom, $urandom);
            sent += walk_len + 1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < insert_top) op = OP_INSERT;
            else if (roll < 55) op = OP_DELETE;
            else if (roll < 70) op = OP_LOOKUP;
            else if (roll < 80) op = OP_REPLACE;
            else if (roll < 93) op = OP_ITER_NEXT;
            else if (roll < 97) op = OP_ITER_RESET;
            else if (roll < 98) op = OP_CLEAR;
            else op = OP_UNKNOWN;
            key = (op == OP_INSERT) ? pick_key() : pick_held_key();
            send_request(op, key, $urandom);
            if (op != OP_UNKNOWN) sent++;
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d results checked: %0d ok, %0d duplicate, %0d full, %0d not found, %0d end",
               sb.responses, sb.status_seen[ST_OK], sb.status_seen[ST_DUPLICATE],
               sb.status_seen[ST_FULL], sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_END]);
      $display("table full after %0d results, empty after %0d, %0d long receiver hold-offs",
               sb.full_seen, sb.empty_seen, holdoffs);
      if (sb.errors == 0) begin
         $display("sorted_key_table_test: clean");
      end else begin
         $display("sorted_key_table_test: errors");
      end
      $finish;
   end

endmodule
